### rtl/core/bmw_pkg.sv
package bmw_pkg;

    localparam int BMW_MAX_RADIUS = 2;
    localparam int BMW_MAX_WIDTH  = 1024;

    // Source frame height limit and the row counter that covers it
    localparam int HEIGHT_LIMIT = 1024;
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int HGT_W        = ROW_W + 1;

    localparam int PIX_W = 8;
    localparam logic [PIX_W-1:0] PIX_FULL  = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_EMPTY = 8'h00;

    // Structuring element mask: 5x5, row major, centered
    localparam int MASK_SIDE  = 5;
    localparam int MASK_REACH = 2;
    localparam int MASK_W     = MASK_SIDE * MASK_SIDE;
    localparam int MASK_IDX_W = $clog2(MASK_W);

    // Configuration port
    localparam int CFG_W     = MASK_W;
    localparam int CFG_IDX_W = 3;
    localparam int RAD_CFG_W = 2;
    localparam int DIM_CFG_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_RADIUS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RADIUS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd5;

    localparam logic [RAD_CFG_W-1:0] RADIUS_RESET = 2'd1;
    localparam logic [MASK_W-1:0]    MASK_RESET   = 25'h1FF_FFFF;
    localparam logic [DIM_CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_CFG_W-1:0] HEIGHT_RESET = 11'd480;

    typedef enum logic
    {
        MODE_DILATE = 1'b0,
        MODE_ERODE  = 1'b1
    } bmw_mode_t;

    // Per-pixel flags that travel with a pixel from the scan counters
    typedef struct packed
    {
        logic produce;
        logic last;
    } bmw_tag_t;

endpackage

### rtl/core/bmw_scan.sv
module bmw_scan
    import bmw_pkg::*;
#(
    parameter int MAX_WIDTH  = BMW_MAX_WIDTH,
    parameter int MAX_RADIUS = BMW_MAX_RADIUS,
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int WW         = (CW + 1 > DIM_CFG_W) ? CW + 1 : DIM_CFG_W,
    parameter int RW         = $clog2(MAX_RADIUS + 1),
    parameter int SW         = $clog2(2 * MAX_RADIUS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [WW-1:0]    width_eff,
    input  logic [HGT_W-1:0] height_eff,
    input  logic [RW-1:0]    x_rad,
    input  logic [RW-1:0]    y_rad,
    output logic [CW-1:0]    col,
    output logic [SW-1:0]    slot,
    output bmw_tag_t         tag
);

    localparam int LINES = 2 * MAX_RADIUS;

    logic [CW-1:0]    col_reg,  col_next;
    logic [ROW_W-1:0] row_reg,  row_next;
    logic [SW-1:0]    slot_reg, slot_next;

    logic             wrap_col;
    logic [HGT_W-1:0] row_pre;
    logic [SW-1:0]    slot_pre;
    logic [ROW_W-1:0] row_cur;
    logic [WW-1:0]    col_inc;
    logic [HGT_W-1:0] row_inc;

    function automatic logic [SW-1:0] slot_step(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        r = (s == SW'(LINES - 1)) ? '0 : s + 1'b1;
        return r;
    endfunction

    always_comb
    begin
        // wrap counters left out of range by a configuration change
        wrap_col = WW'(col_reg) >= width_eff;
        row_pre  = wrap_col ? {1'b0, row_reg} + 1'b1 : {1'b0, row_reg};
        slot_pre = wrap_col ? slot_step(slot_reg) : slot_reg;
        if (row_pre >= height_eff)
        begin
            row_cur = '0;
            slot    = '0;
        end
        else
        begin
            row_cur = row_pre[ROW_W-1:0];
            slot    = slot_pre;
        end
        col = wrap_col ? '0 : col_reg;

        // advance to the next pixel position
        col_inc   = WW'(col) + 1'b1;
        row_inc   = {1'b0, row_cur} + 1'b1;
        col_next  = col_inc[CW-1:0];
        row_next  = row_cur;
        slot_next = slot;
        if (col_inc >= width_eff)
        begin
            col_next = '0;
            if (row_inc >= height_eff)
            begin
                row_next  = '0;
                slot_next = '0;
            end
            else
            begin
                row_next  = row_inc[ROW_W-1:0];
                slot_next = slot_step(slot);
            end
        end

        tag.produce = ({1'b0, row_cur} >= HGT_W'({y_rad, 1'b0}))
                   && (WW'(col) >= WW'({x_rad, 1'b0}));
        tag.last    = ({1'b0, row_cur} == height_eff - 1'b1)
                   && (WW'(col) == width_eff - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SW'(LINES - 1))
        else $error("line slot out of range");

    a_slot_row0: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg == '0 |-> slot_reg == '0)
        else $error("line slot not aligned to row zero");

endmodule

### rtl/core/bmw_line_store.sv
module bmw_line_store
    import bmw_pkg::*;
#(
    parameter int MAX_WIDTH  = BMW_MAX_WIDTH,
    parameter int MAX_RADIUS = BMW_MAX_RADIUS,
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int SW         = $clog2(2 * MAX_RADIUS)
)
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [CW-1:0]                        addr,
    input  logic [SW-1:0]                        wr_slot,
    input  logic [PIX_W-1:0]                     wr_data,
    output logic [2*MAX_RADIUS-1:0][PIX_W-1:0]   rd_data
);

    localparam int LINES = 2 * MAX_RADIUS;

    // One word per column, one byte lane per stored line
    logic [LINES-1:0][PIX_W-1:0] mem [MAX_WIDTH];
    logic [LINES-1:0][PIX_W-1:0] rd_data_reg;

    // Read old contents and overwrite one lane at the same column
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_data_reg        <= mem[addr];
            mem[addr][wr_slot] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/bmw_window.sv
module bmw_window
    import bmw_pkg::*;
#(
    parameter int MAX_RADIUS = BMW_MAX_RADIUS,
    parameter int RW         = $clog2(MAX_RADIUS + 1),
    parameter int SW         = $clog2(2 * MAX_RADIUS)
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [PIX_W-1:0]                   pix,
    input  logic [SW-1:0]                      slot,
    input  bmw_tag_t                           tag,
    input  logic [2*MAX_RADIUS-1:0][PIX_W-1:0] rd_data,
    input  bmw_mode_t                          mode,
    input  logic [MASK_W-1:0]                  element_mask,
    input  logic [RW-1:0]                      x_rad,
    input  logic [RW-1:0]                      y_rad,
    input  logic                               out_stall,
    output logic                               busy,
    output logic                               out_valid,
    output logic [PIX_W-1:0]                   pixel_out,
    output logic                               frame_last
);

    localparam int LINES = 2 * MAX_RADIUS;
    localparam int WIN   = 2 * MAX_RADIUS + 1;
    localparam int CIW   = $clog2(WIN);

    logic             s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0] pix_reg;
    logic [SW-1:0]    slot_reg;
    bmw_tag_t         tag_reg;

    logic [PIX_W-1:0] win_reg  [WIN][WIN];
    logic [PIX_W-1:0] win_next [WIN][WIN];

    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] pixel_out_reg;
    logic             last_reg;

    logic             out_free;
    logic             s1_move;
    logic             load_out;
    logic             hit;
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] result;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign busy     = s1_valid_reg && !out_free;
    assign load_out = s1_move && tag_reg.produce;

    // Shift the window one column and evaluate the structuring element
    always_comb
    begin
        int lane;
        int oy;
        int ox;
        hit = 1'b0;
        for (int i = 0; i < WIN; i++)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                if (j == 0)
                begin
                    if (i == 0)
                    begin
                        win_next[i][j] = pix_reg;
                    end
                    else
                    begin
                        lane = int'(slot_reg) + LINES - i;
                        if (lane >= LINES)
                        begin
                            lane = lane - LINES;
                        end
                        win_next[i][j] = rd_data[SW'(lane)];
                    end
                end
                else
                begin
                    win_next[i][j] = win_reg[i][j-1];
                end
            end
        end
        for (int i = 0; i < WIN; i++)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                oy = int'(y_rad) - i;
                ox = int'(x_rad) - j;
                if (i <= 2 * int'(y_rad) && j <= 2 * int'(x_rad)
                    && oy >= -MASK_REACH && oy <= MASK_REACH
                    && ox >= -MASK_REACH && ox <= MASK_REACH)
                begin
                    if (element_mask[MASK_IDX_W'((oy + MASK_REACH) * MASK_SIDE
                                                 + ox + MASK_REACH)])
                    begin
                        if (mode == MODE_DILATE)
                        begin
                            hit = hit | (win_next[i][j] != PIX_EMPTY);
                        end
                        else
                        begin
                            hit = hit | (win_next[i][j] == PIX_EMPTY);
                        end
                    end
                end
            end
        end
        center = win_next[CIW'(y_rad)][CIW'(x_rad)];
        result = center;
        if (mode == MODE_DILATE)
        begin
            if (center == PIX_EMPTY && hit)
            begin
                result = PIX_FULL;
            end
        end
        else
        begin
            if (center != PIX_EMPTY && hit)
            begin
                result = PIX_EMPTY;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg && out_stall;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg  <= pix;
            slot_reg <= slot;
            tag_reg  <= tag;
        end
        if (s1_move)
        begin
            win_reg <= win_next;
        end
        if (load_out)
        begin
            pixel_out_reg <= result;
            last_reg      <= tag_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign frame_last = last_reg;

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && tag_reg.produce))
        else $error("output raised without a covered window");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !busy)
        else $error("window stage overwritten while held");

endmodule

### rtl/core/binary_morphology_window.sv
// Binary dilation / erosion over a sliding window of up to 5x5 pixels.
// An accepted pixel is registered in the window stage, then its result in the output register.
// Throughput: one pixel per clock unless a stalled output holds the window stage, set by the
//   single line store port that reads and writes one column word per pixel.
// Reset: configuration returns to its defaults, scan counters and pipeline
//   clear; the line store is not cleared, so no clearing pass is run.
module binary_morphology_window
    import bmw_pkg::*;
#(
    parameter int MAX_RADIUS = BMW_MAX_RADIUS,
    parameter int MAX_WIDTH  = BMW_MAX_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // configuration writes
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    // source pixel transactions
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PIX_W-1:0]     pixel_in,

    // result pixel transactions
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [PIX_W-1:0]     pixel_out,
    output logic                 frame_last
);

    localparam int LINES = 2 * MAX_RADIUS;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = (CW + 1 > DIM_CFG_W) ? CW + 1 : DIM_CFG_W;
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int SW    = $clog2(LINES);

    // Configuration registers
    bmw_mode_t            mode_reg;
    logic [RAD_CFG_W-1:0] x_radius_reg;
    logic [RAD_CFG_W-1:0] y_radius_reg;
    logic [MASK_W-1:0]    element_mask_reg;
    logic [DIM_CFG_W-1:0] image_width_reg;
    logic [DIM_CFG_W-1:0] image_height_reg;

    // Effective (clamped) settings
    logic [WW-1:0]    width_eff;
    logic [HGT_W-1:0] height_eff;
    logic [RW-1:0]    x_rad;
    logic [RW-1:0]    y_rad;

    logic                        accept;
    logic                        busy;
    logic [CW-1:0]               col;
    logic [SW-1:0]               slot;
    bmw_tag_t                    tag;
    logic [LINES-1:0][PIX_W-1:0] rd_data;

    // The user changes registers only between frames, while the pipeline is empty; not enforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_DILATE;
            x_radius_reg     <= RADIUS_RESET;
            y_radius_reg     <= RADIUS_RESET;
            element_mask_reg <= MASK_RESET;
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MODE:         mode_reg         <= bmw_mode_t'(cfg_data[0]);
                CFG_X_RADIUS:     x_radius_reg     <= cfg_data[RAD_CFG_W-1:0];
                CFG_Y_RADIUS:     y_radius_reg     <= cfg_data[RAD_CFG_W-1:0];
                CFG_ELEMENT_MASK: element_mask_reg <= cfg_data[MASK_W-1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_CFG_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp the frame size to the line store depth and the row counter
    // range, and the radii to what the window holds. A zero size acts as one.
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            width_eff = WW'(1);
        end
        else if (WW'(image_width_reg) > WW'(MAX_WIDTH))
        begin
            width_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = WW'(image_width_reg);
        end

        if (image_height_reg == '0)
        begin
            height_eff = HGT_W'(1);
        end
        else if (HGT_W'(image_height_reg) > HGT_W'(HEIGHT_LIMIT))
        begin
            height_eff = HGT_W'(HEIGHT_LIMIT);
        end
        else
        begin
            height_eff = HGT_W'(image_height_reg);
        end

        x_rad = (int'(x_radius_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(x_radius_reg);
        y_rad = (int'(y_radius_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(y_radius_reg);
    end

    // Take a new pixel whenever the window stage can hand its pixel on;
    // one result may wait in the output register meanwhile.
    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    // Scan position: column, row and line slot of the arriving pixel
    bmw_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS),
        .CW         (CW),
        .WW         (WW),
        .RW         (RW),
        .SW         (SW)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .x_rad      (x_rad),
        .y_rad      (y_rad),
        .col        (col),
        .slot       (slot),
        .tag        (tag)
    );

    // Line store: read the column of the previous lines and write the new
    // pixel into its own line in the same cycle
    bmw_line_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS),
        .CW         (CW),
        .SW         (SW)
    ) u_line_store (
        .clk        (clk),
        .en         (accept),
        .addr       (col),
        .wr_slot    (slot),
        .wr_data    (pixel_in),
        .rd_data    (rd_data)
    );

    // Window registers, structuring element test and output register
    bmw_window #(
        .MAX_RADIUS   (MAX_RADIUS),
        .RW           (RW),
        .SW           (SW)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .pix          (pixel_in),
        .slot         (slot),
        .tag          (tag),
        .rd_data      (rd_data),
        .mode         (mode_reg),
        .element_mask (element_mask_reg),
        .x_rad        (x_rad),
        .y_rad        (y_rad),
        .out_stall    (out_stall),
        .busy         (busy),
        .out_valid    (out_valid),
        .pixel_out    (pixel_out),
        .frame_last   (frame_last)
    );

endmodule
